### src/dlpt_pkg.sv
package dlpt_pkg;

  // Default width of the tracked line counter.
  localparam int LINE_WIDTH_DEF = 32;

  // Operand size kinds.
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_TWO  = 2'd1,
    KIND_FOUR = 2'd2,
    KIND_STR  = 2'd3
  } kind_t;

  // Section tags.
  localparam logic [1:0] SEC_D1 = 2'd1;
  localparam logic [1:0] SEC_D2 = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_D2_SIZE = 3'd1;
  localparam logic [2:0] ERR_VERSION = 3'd2;
  localparam logic [2:0] ERR_SUBOP   = 3'd3;
  localparam logic [2:0] ERR_NONZERO = 3'd4;
  localparam logic [2:0] ERR_BYTE    = 3'd5;
  localparam logic [2:0] ERR_D1_SIZE = 3'd6;
  localparam logic [2:0] ERR_RANGE0  = 3'd7;

  // Standard opcodes and extended subopcodes.
  localparam logic [7:0] OP_EXTENDED  = 8'd0;
  localparam logic [7:0] OP_COPY      = 8'd1;
  localparam logic [7:0] OP_ADV_PC    = 8'd2;
  localparam logic [7:0] OP_ADV_LINE  = 8'd3;
  localparam logic [7:0] OP_SET_FILE  = 8'd4;
  localparam logic [7:0] OP_SET_COL   = 8'd5;
  localparam logic [7:0] OP_NEG_STMT  = 8'd6;
  localparam logic [7:0] OP_BASIC_BLK = 8'd7;
  localparam logic [7:0] OP_CONST_PC  = 8'd8;
  localparam logic [7:0] OP_FIXED_PC  = 8'd9;
  localparam logic [31:0] XOP_END_SEQ  = 32'd1;
  localparam logic [31:0] XOP_SET_ADDR = 32'd2;
  localparam logic [31:0] XOP_DEF_FILE = 32'd3;

  localparam logic [31:0] LINE_PROG_VERSION = 32'd2;

  typedef struct packed {
    logic [1:0]  section;
    logic [1:0]  kind;
    logic [31:0] value;
    logic        string_empty;
  } item_t;

  typedef struct packed {
    logic        line_valid;
    logic [31:0] line_number;
    logic [31:0] file_number;
    logic [2:0]  error_code;
  } result_t;

endpackage

### src/dwarf_line_program_tracker_top.sv
// Line-number program tracker. One pre-parsed item is taken per transfer and one result
// is returned for it. For most items the result is presented on the cycle after the
// transfer, and the next item can be taken as that result leaves. A special opcode
// loads the remainder unit, which makes eight remainder steps that reduce the adjusted
// opcode by the stored line span; the remainder is then folded into the line, and the
// next item can be taken once that result is presented. No new item is taken while a
// special opcode is in the remainder unit or while a result is stalled. After any error
// the block answers every item with that error code until reset.
module dwarf_line_program_tracker_top import dlpt_pkg::*; #(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  typedef enum logic [4:0] {
    P_SIZE, P_VER, P_PSIZE, P_MININST, P_DEFSTMT, P_LBASE, P_LRANGE, P_OBASE,
    P_OPLEN, P_INCDIR, P_FNAME, P_FIDX, P_FTIME, P_FSIZE, P_OP, P_XLEN,
    P_XSUB, P_ADVLN, P_SKIPLEB, P_SETFILE, P_ADDR2, P_ADDR4
  } d2_phase_t;

  typedef enum logic [2:0] {D1_SZ, D1_ST, D1_LN, D1_CH, D1_AD} d1_phase_t;

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  state_t            state;
  d2_phase_t         d2_phase, d2_phase_next;
  d1_phase_t         d1_phase, d1_phase_next;
  logic [7:0]        base_step, base_step_next;
  logic [7:0]        line_span, line_span_next;
  logic [7:0]        special_base, special_base_next;
  logic [7:0]        op_count_left, op_count_left_next;
  logic              defined_file_seen, defined_file_seen_next;
  logic [LINE_WIDTH-1:0] current_line, current_line_next;
  logic [31:0]       current_file, current_file_next;
  logic [31:0]       leb_accum, leb_accum_next;
  logic [5:0]        leb_shift, leb_shift_next;
  logic              halted;
  logic [2:0]        err_hold;
  logic              adj_neg;

  logic              accept;
  logic              out_free;
  logic              res_load;
  logic [2:0]        err;
  logic              rep_valid;
  logic [31:0]       rep_line;
  logic [31:0]       rep_file;
  logic              div_start;
  logic              div_done;
  logic [7:0]        div_rem;
  logic [8:0]        adj;
  logic [7:0]        adj_mag;

  logic [31:0]       v;
  logic              byte_wide;
  logic              leb_end;
  logic              leb_sgn;
  logic [31:0]       leb_keep;
  logic [5:0]        leb_shift_adv;
  logic [6:0]        shift_plus7;

  logic [8:0]        rem_signed;
  logic [9:0]        line_step;

  assign v         = item.value;
  assign byte_wide = (v > 32'd255);
  assign out_free  = !result_valid || !result_stall;
  assign item_stall = (state != ST_IDLE) || !out_free;
  assign accept    = item_valid && !item_stall;

  // LEB128 byte step shared by every LEB field; only the line advance is signed.
  assign leb_end     = !v[7];
  assign leb_sgn     = (d2_phase == P_ADVLN);
  assign shift_plus7 = {1'b0, leb_shift} + 7'd7;
  always_comb begin
    leb_keep = (leb_shift == 6'd0) ? 32'd0 : leb_accum;
    if (leb_shift < 6'd32) begin
      leb_keep = leb_keep | ({25'd0, v[6:0]} << leb_shift[4:0]);
    end
    if (leb_sgn && leb_end && v[6] && (shift_plus7 < 7'd32)) begin
      leb_keep = leb_keep | (32'hFFFF_FFFF << shift_plus7[4:0]);
    end
    leb_shift_adv = (leb_shift >= 6'd57) ? 6'd63 : shift_plus7[5:0];
  end

  // Adjusted special opcode and its magnitude for the remainder unit.
  assign adj     = {1'b0, v[7:0]} - {1'b0, special_base};
  assign adj_mag = adj[8] ? 8'(-adj) : adj[7:0];

  // Per-item decode.
  always_comb begin
    err                    = ERR_NONE;
    rep_valid              = 1'b0;
    rep_line               = 32'd0;
    rep_file               = 32'd0;
    div_start              = 1'b0;
    d2_phase_next          = d2_phase;
    d1_phase_next          = d1_phase;
    base_step_next         = base_step;
    line_span_next         = line_span;
    special_base_next      = special_base;
    op_count_left_next     = op_count_left;
    defined_file_seen_next = defined_file_seen;
    current_line_next      = current_line;
    current_file_next      = current_file;
    leb_accum_next         = leb_accum;
    leb_shift_next         = leb_shift;

    if (item.section == SEC_D1) begin
      if (item.kind != ((d1_phase == D1_CH) ? KIND_TWO : KIND_FOUR)) begin
        err = ERR_D1_SIZE;
      end else begin
        case (d1_phase)
          D1_SZ: d1_phase_next = D1_ST;
          D1_ST: d1_phase_next = D1_LN;
          D1_LN: begin
            d1_phase_next = D1_CH;
            rep_valid     = 1'b1;
            rep_line      = v;
            rep_file      = 32'd1;
          end
          D1_CH: d1_phase_next = D1_AD;
          default: d1_phase_next = D1_LN;
        endcase
      end
    end else if (item.section == SEC_D2) begin
      if (d2_phase == P_INCDIR || d2_phase == P_FNAME) begin
        // Directory and file name lists end on a zero byte or an empty string.
        if (item.kind == KIND_BYTE) begin
          if (v != 32'd0) begin
            err = ERR_NONZERO;
          end else begin
            d2_phase_next = (d2_phase == P_INCDIR) ? P_FNAME : P_OP;
          end
        end else if (item.kind != KIND_STR) begin
          err = ERR_D2_SIZE;
        end else if (d2_phase == P_INCDIR) begin
          if (item.string_empty) begin
            d2_phase_next = P_FNAME;
          end
        end else begin
          d2_phase_next = item.string_empty ? P_OP : P_FIDX;
        end
      end else if ((d2_phase == P_SIZE || d2_phase == P_PSIZE || d2_phase == P_ADDR4)
                   ? (item.kind != KIND_FOUR)
                   : (d2_phase == P_VER || d2_phase == P_ADDR2)
                   ? (item.kind != KIND_TWO) : (item.kind != KIND_BYTE)) begin
        err = ERR_D2_SIZE;
      end else if (byte_wide && (d2_phase == P_FIDX || d2_phase == P_FTIME ||
                   d2_phase == P_FSIZE || d2_phase == P_XLEN || d2_phase == P_ADVLN ||
                   d2_phase == P_SKIPLEB || d2_phase == P_SETFILE || d2_phase == P_OP)) begin
        err = ERR_BYTE;
      end else begin
        case (d2_phase)
          P_SIZE: d2_phase_next = P_VER;
          P_VER: begin
            if (v != LINE_PROG_VERSION) begin
              err = ERR_VERSION;
            end else begin
              d2_phase_next = P_PSIZE;
            end
          end
          P_PSIZE:   d2_phase_next = P_MININST;
          P_MININST: d2_phase_next = P_DEFSTMT;
          P_DEFSTMT: d2_phase_next = P_LBASE;
          P_LBASE: begin
            base_step_next = v[7:0];
            d2_phase_next  = P_LRANGE;
          end
          P_LRANGE: begin
            line_span_next = v[7:0];
            d2_phase_next  = P_OBASE;
          end
          P_OBASE: begin
            special_base_next = v[7:0];
            if (v[7:0] <= 8'd1) begin
              d2_phase_next = P_INCDIR;
            end else begin
              op_count_left_next = v[7:0] - 8'd1;
              d2_phase_next      = P_OPLEN;
            end
          end
          P_OPLEN: begin
            op_count_left_next = op_count_left - 8'd1;
            if (op_count_left == 8'd1) begin
              d2_phase_next = P_INCDIR;
            end
          end
          P_FIDX, P_FTIME, P_FSIZE, P_XLEN, P_SKIPLEB: begin
            leb_shift_next = leb_end ? 6'd0 : leb_shift_adv;
            if (leb_end) begin
              case (d2_phase)
                P_FIDX:  d2_phase_next = P_FTIME;
                P_FTIME: d2_phase_next = P_FSIZE;
                P_FSIZE: d2_phase_next = defined_file_seen ? P_OP : P_FNAME;
                P_XLEN:  d2_phase_next = P_XSUB;
                default: d2_phase_next = P_OP;
              endcase
            end
          end
          P_OP: begin
            case (v[7:0])
              OP_EXTENDED: d2_phase_next = P_XLEN;
              OP_COPY, OP_NEG_STMT, OP_BASIC_BLK, OP_CONST_PC: d2_phase_next = P_OP;
              OP_ADV_LINE: d2_phase_next = P_ADVLN;
              OP_ADV_PC, OP_SET_COL: d2_phase_next = P_SKIPLEB;
              OP_SET_FILE: d2_phase_next = P_SETFILE;
              OP_FIXED_PC: d2_phase_next = P_ADDR2;
              default: begin
                // Special opcode: the line step needs a remainder by the line span.
                if (line_span == 8'd0) begin
                  err = ERR_RANGE0;
                end else begin
                  div_start = 1'b1;
                end
              end
            endcase
          end
          P_XSUB: begin
            if (v == XOP_END_SEQ) begin
              current_line_next = LINE_WIDTH'(1);
              current_file_next = 32'd1;
              d2_phase_next     = P_OP;
            end else if (v == XOP_SET_ADDR) begin
              d2_phase_next = P_ADDR4;
            end else if (v == XOP_DEF_FILE) begin
              defined_file_seen_next = 1'b1;
              d2_phase_next          = P_FNAME;
            end else begin
              err = ERR_SUBOP;
            end
          end
          P_ADVLN: begin
            leb_accum_next = leb_keep;
            leb_shift_next = leb_end ? 6'd0 : leb_shift_adv;
            if (leb_end) begin
              current_line_next = current_line +
                                  LINE_WIDTH'({{32{leb_keep[31]}}, leb_keep});
              d2_phase_next     = P_OP;
              rep_valid         = 1'b1;
              rep_line          = 32'(64'(current_line_next));
              rep_file          = current_file;
            end
          end
          P_SETFILE: begin
            leb_accum_next = leb_keep;
            leb_shift_next = leb_end ? 6'd0 : leb_shift_adv;
            if (leb_end) begin
              current_file_next = leb_keep;
              d2_phase_next     = P_OP;
            end
          end
          default: d2_phase_next = P_OP;
        endcase
      end
    end
  end

  // Shared remainder unit for special opcodes.
  dlpt_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && !halted && div_start),
    .dividend (adj_mag),
    .divisor  (line_span),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Signed remainder (truncating toward zero) plus the base step gives the line step.
  assign rem_signed = adj_neg ? 9'(-{1'b0, div_rem}) : {1'b0, div_rem};
  assign line_step  = {{2{base_step[7]}}, base_step} + {rem_signed[8], rem_signed};

  // A result is loaded on every transfer except one that starts the remainder unit,
  // and again when the remainder unit finishes.
  assign res_load = (state == ST_IDLE)
                    ? (accept && (halted || (err != ERR_NONE) || !div_start))
                    : div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      d2_phase          <= P_SIZE;
      d1_phase          <= D1_SZ;
      base_step         <= 8'd0;
      line_span         <= 8'd0;
      special_base      <= 8'd0;
      op_count_left     <= 8'd0;
      defined_file_seen <= 1'b0;
      current_line      <= LINE_WIDTH'(1);
      current_file      <= 32'd1;
      leb_accum         <= 32'd0;
      leb_shift         <= 6'd0;
      halted            <= 1'b0;
      err_hold          <= ERR_NONE;
      result_valid      <= 1'b0;
    end else begin
      // A waiting result leaves on its transfer unless a new one replaces it.
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (halted) begin
              result       <= '{line_valid: 1'b0, line_number: 32'd0,
                                file_number: 32'd0, error_code: err_hold};
            end else if (err != ERR_NONE) begin
              halted       <= 1'b1;
              err_hold     <= err;
              result       <= '{line_valid: 1'b0, line_number: 32'd0,
                                file_number: 32'd0, error_code: err};
            end else if (div_start) begin
              adj_neg <= adj[8];
              state   <= ST_DIV;
            end else begin
              d2_phase          <= d2_phase_next;
              d1_phase          <= d1_phase_next;
              base_step         <= base_step_next;
              line_span         <= line_span_next;
              special_base      <= special_base_next;
              op_count_left     <= op_count_left_next;
              defined_file_seen <= defined_file_seen_next;
              current_line      <= current_line_next;
              current_file      <= current_file_next;
              leb_accum         <= leb_accum_next;
              leb_shift         <= leb_shift_next;
              result            <= '{line_valid: rep_valid, line_number: rep_line,
                                     file_number: rep_file, error_code: ERR_NONE};
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            current_line <= current_line + LINE_WIDTH'({{54{line_step[9]}}, line_step});
            result       <= '{line_valid: 1'b1,
                              line_number: 32'(64'(current_line +
                                LINE_WIDTH'({{54{line_step[9]}}, line_step}))),
                              file_number: current_file, error_code: ERR_NONE};
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A special opcode holds off further transfers until its line is known.
  a_div_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> item_stall)
    else $error("item taken while remainder unit busy");

  // Once halted, the block stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt released without reset");

  // A halted block never presents a line record.
  a_halt_no_line: assert property (@(posedge clk) disable iff (rst)
    (halted && result_valid) |-> !result.line_valid)
    else $error("line record while halted");

  // The remainder unit only finishes while a special opcode is pending.
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("remainder done outside special opcode");

endmodule

### src/dlpt_rem.sv
// Restoring remainder unit: one quotient bit per cycle.
module dlpt_rem import dlpt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] rem
);

  logic       busy;
  logic [2:0] count;
  logic [7:0] shreg;
  logic [7:0] dvs;
  logic [8:0] trial;

  // Bring the next dividend bit into the partial remainder.
  assign trial = {rem, shreg[7]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 3'd0;
        shreg <= dividend;
        dvs   <= divisor;
        rem   <= 8'd0;
      end else if (busy) begin
        shreg <= {shreg[6:0], 1'b0};
        if (trial >= {1'b0, dvs}) begin
          rem <= 8'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[7:0];
        end
        count <= count + 3'd1;
        if (count == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### test/tb_dwarf_line_program_tracker_top.sv
`timescale 1ns / 1ps

module tb_dwarf_line_program_tracker_top;
  import dlpt_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam int MAX_REPORTS = 10;

  // Line-program decode phases, in the order the header and opcode stream visit them.
  typedef enum logic [4:0] {
    PH_SIZE, PH_VER, PH_PSIZE, PH_MININST, PH_DEFSTMT, PH_LBASE, PH_LRANGE, PH_OBASE,
    PH_OPLEN, PH_INCDIR, PH_FNAME, PH_FIDX, PH_FTIME, PH_FSIZE, PH_OP, PH_XLEN,
    PH_XSUB, PH_ADVLN, PH_SKIPLEB, PH_SETFILE, PH_ADDR2, PH_ADDR4
  } prog_phase_t;

  // Phases of the older line-section record walk.
  typedef enum logic [2:0] {
    D1_SIZE, D1_ORIGIN, D1_LINE, D1_CHAR, D1_ADDR
  } rec_phase_t;

  typedef struct {
    item_t   it;
    bit      fixed;
    result_t want;
  } dir_row_t;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  dwarf_line_program_tracker_top DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Tracker state as the predictor sees it.
  prog_phase_t prog_phase;
  rec_phase_t  rec_phase;
  logic [7:0]  base_step, line_span, special_base, oplen_left;
  logic        file_defined;
  logic [31:0] cur_line, cur_file, leb_acc;
  logic [5:0]  leb_sh;
  logic        halted;
  logic [2:0]  held_err;
  logic        rec_valid;
  logic [31:0] rec_line, rec_file;

  result_t expected_results[$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      send_idle = 0;
  int      recv_stall = 0;
  int      err_pick;

  // Take one LEB128 byte; returns 1 on the last byte of the number.
  function automatic bit leb_take(logic [31:0] v, bit keep, bit sgn);
    logic [63:0] part;
    int          nxt;
    if (keep) begin
      if (leb_sh == 0) leb_acc = '0;
      part = {57'd0, v[6:0]} << leb_sh;
      if (leb_sh < 32) leb_acc |= part[31:0];
    end
    if (!v[7]) begin
      if (keep && sgn && v[6] && (leb_sh + 7 < 32)) leb_acc |= 32'hFFFF_FFFF << (leb_sh + 7);
      leb_sh = '0;
      return 1'b1;
    end
    nxt = leb_sh + 7;
    leb_sh = (nxt > 63) ? 6'd63 : 6'(nxt);
    return 1'b0;
  endfunction

  function automatic void report_line();
    rec_valid = 1'b1;
    rec_line = cur_line;
    rec_file = cur_file;
  endfunction

  function automatic logic [2:0] rec_take(logic [1:0] kind, logic [31:0] v);
    logic [1:0] need;
    need = (rec_phase == D1_CHAR) ? KIND_TWO : KIND_FOUR;
    if (kind != need) return ERR_D1_SIZE;
    case (rec_phase)
      D1_SIZE:   rec_phase = D1_ORIGIN;
      D1_ORIGIN: rec_phase = D1_LINE;
      D1_LINE: begin
        rec_phase = D1_CHAR;
        rec_valid = 1'b1;
        rec_line = v;
        rec_file = 32'd1;
      end
      D1_CHAR:  rec_phase = D1_ADDR;
      default:  rec_phase = D1_LINE;
    endcase
    return ERR_NONE;
  endfunction

  function automatic logic [2:0] prog_take(logic [1:0] kind, logic [31:0] v,
                                           logic empty);
    prog_phase_t p;
    int          adj, lb;
    p = prog_phase;
    // Directory and file-name lists: strings, closed by an empty string or a zero byte.
    if (p == PH_INCDIR || p == PH_FNAME) begin
      if (kind == KIND_BYTE) begin
        if (v != 0) return ERR_NONZERO;
        prog_phase = (p == PH_INCDIR) ? PH_FNAME : PH_OP;
        return ERR_NONE;
      end
      if (kind != KIND_STR) return ERR_D2_SIZE;
      if (p == PH_INCDIR) begin
        if (empty) prog_phase = PH_FNAME;
      end else begin
        prog_phase = empty ? PH_OP : PH_FIDX;
      end
      return ERR_NONE;
    end
    // Operand size and byte range checks.
    if (p == PH_SIZE || p == PH_PSIZE || p == PH_ADDR4) begin
      if (kind != KIND_FOUR) return ERR_D2_SIZE;
    end else if (p == PH_VER || p == PH_ADDR2) begin
      if (kind != KIND_TWO) return ERR_D2_SIZE;
    end else if (kind != KIND_BYTE) begin
      return ERR_D2_SIZE;
    end
    if ((p >= PH_FIDX && p <= PH_FSIZE) || p == PH_XLEN ||
        (p >= PH_ADVLN && p <= PH_SETFILE))
      if (v > 255) return ERR_BYTE;

    case (p)
      PH_SIZE: prog_phase = PH_VER;
      PH_VER: begin
        if (v != LINE_PROG_VERSION) return ERR_VERSION;
        prog_phase = PH_PSIZE;
      end
      PH_PSIZE:   prog_phase = PH_MININST;
      PH_MININST: prog_phase = PH_DEFSTMT;
      PH_DEFSTMT: prog_phase = PH_LBASE;
      PH_LBASE: begin
        base_step = v[7:0];
        prog_phase = PH_LRANGE;
      end
      PH_LRANGE: begin
        line_span = v[7:0];
        prog_phase = PH_OBASE;
      end
      PH_OBASE: begin
        special_base = v[7:0];
        if (v[7:0] <= 1) begin
          prog_phase = PH_INCDIR;
        end else begin
          oplen_left = v[7:0] - 8'd1;
          prog_phase = PH_OPLEN;
        end
      end
      PH_OPLEN: begin
        oplen_left = oplen_left - 8'd1;
        if (oplen_left == 0) prog_phase = PH_INCDIR;
      end
      PH_FIDX:  if (leb_take(v, 0, 0)) prog_phase = PH_FTIME;
      PH_FTIME: if (leb_take(v, 0, 0)) prog_phase = PH_FSIZE;
      PH_FSIZE: if (leb_take(v, 0, 0)) prog_phase = file_defined ? PH_OP : PH_FNAME;
      PH_OP: begin
        if (v > 255) return ERR_BYTE;
        case (v[7:0])
          OP_EXTENDED: prog_phase = PH_XLEN;
          OP_COPY, OP_NEG_STMT, OP_BASIC_BLK, OP_CONST_PC: ;
          OP_ADV_LINE: prog_phase = PH_ADVLN;
          OP_ADV_PC, OP_SET_COL: prog_phase = PH_SKIPLEB;
          OP_SET_FILE: prog_phase = PH_SETFILE;
          OP_FIXED_PC: prog_phase = PH_ADDR2;
          default: begin
            // Special opcode: the remainder truncates toward zero, as a signed divide does.
            if (line_span == 0) return ERR_RANGE0;
            adj = int'(v) - int'(special_base);
            lb = int'($signed(base_step));
            lb += adj % int'(line_span);
            cur_line = cur_line + 32'(lb);
            report_line();
          end
        endcase
      end
      PH_XLEN: if (leb_take(v, 0, 0)) prog_phase = PH_XSUB;
      PH_XSUB: begin
        if (v == XOP_END_SEQ) begin
          cur_line = 32'd1;
          cur_file = 32'd1;
          prog_phase = PH_OP;
        end else if (v == XOP_SET_ADDR) begin
          prog_phase = PH_ADDR4;
        end else if (v == XOP_DEF_FILE) begin
          file_defined = 1'b1;
          prog_phase = PH_FNAME;
        end else begin
          return ERR_SUBOP;
        end
      end
      PH_ADVLN: begin
        if (leb_take(v, 1, 1)) begin
          cur_line = cur_line + leb_acc;
          prog_phase = PH_OP;
          report_line();
        end
      end
      PH_SKIPLEB: if (leb_take(v, 0, 0)) prog_phase = PH_OP;
      PH_SETFILE: begin
        if (leb_take(v, 1, 0)) begin
          cur_file = leb_acc;
          prog_phase = PH_OP;
        end
      end
      default: prog_phase = PH_OP;
    endcase
    return ERR_NONE;
  endfunction

  // Result the tracker owes for one accepted item.
  function automatic result_t predict_line(item_t it);
    result_t    r;
    logic [2:0] e;
    r = '0;
    if (halted) begin
      r.error_code = held_err;
      return r;
    end
    rec_valid = 1'b0;
    rec_line = '0;
    rec_file = '0;
    e = ERR_NONE;
    if (it.section == SEC_D2) e = prog_take(it.kind, it.value, it.string_empty);
    else if (it.section == SEC_D1) e = rec_take(it.kind, it.value);
    if (e != ERR_NONE) begin
      halted = 1'b1;
      held_err = e;
      r.error_code = e;
      return r;
    end
    if (rec_valid) begin
      r.line_valid = 1'b1;
      r.line_number = rec_line;
      r.file_number = rec_file;
    end
    return r;
  endfunction

  // Drive one item and wait for its transfer. Valid stays up afterwards; callers that
  // pause lower it themselves.
  task automatic send(logic [1:0] sec, logic [1:0] kind, logic [31:0] v, logic empty,
                      bit fixed = 1'b0, result_t want = '0);
    item_t   it;
    result_t p;
    it.section = sec;
    it.kind = kind;
    it.value = v;
    it.string_empty = empty;
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    p = predict_line(it);
    expected_results.push_back(fixed ? want : p);
    if (sec == SEC_D1 || sec == SEC_D2) items_sent++;
  endtask

  task automatic prog_byte(logic [31:0] v);
    send(SEC_D2, KIND_BYTE, v, 1'b0);
  endtask

  task automatic prog_op(logic [7:0] op);
    prog_byte({24'd0, op});
  endtask

  task automatic prog_str(logic empty);
    send(SEC_D2, KIND_STR, $urandom, empty);
  endtask

  // A LEB128 number: mostly one byte, sometimes long enough to saturate the shift.
  task automatic gen_leb();
    int r, n;
    r = $urandom_range(19);
    n = (r < 12) ? 1 : (r < 18) ? $urandom_range(2, 3) : $urandom_range(5, 11);
    repeat (n - 1) prog_byte(32'h80 | $urandom_range(127));
    prog_byte($urandom_range(127));
  endtask

  task automatic gen_file_entry();
    prog_str(1'b0);
    repeat (3) gen_leb();
  endtask

  task automatic gen_list_end();
    if ($urandom_range(1)) prog_str(1'b1);
    else prog_byte(32'd0);
  endtask

  // One well-formed opcode with its operands, or an interleaved foreign item.
  task automatic gen_op();
    int r;
    r = $urandom_range(99);
    if (r < 35) begin
      if (err_pick != ERR_RANGE0) prog_byte($urandom_range(10, 255));
      else prog_op(OP_COPY);
    end else if (r < 45) begin
      case ($urandom_range(3))
        0: prog_op(OP_COPY);
        1: prog_op(OP_NEG_STMT);
        2: prog_op(OP_BASIC_BLK);
        default: prog_op(OP_CONST_PC);
      endcase
    end else if (r < 58) begin
      prog_op(OP_ADV_LINE);
      gen_leb();
    end else if (r < 65) begin
      prog_op($urandom_range(1) ? OP_ADV_PC : OP_SET_COL);
      gen_leb();
    end else if (r < 72) begin
      prog_op(OP_SET_FILE);
      gen_leb();
    end else if (r < 77) begin
      prog_op(OP_FIXED_PC);
      send(SEC_D2, KIND_TWO, $urandom, 1'b0);
    end else if (r < 89) begin
      prog_op(OP_EXTENDED);
      gen_leb();
      if (r < 82) begin
        prog_byte(XOP_END_SEQ);
      end else if (r < 86) begin
        prog_byte(XOP_SET_ADDR);
        send(SEC_D2, KIND_FOUR, $urandom, 1'b0);
      end else begin
        prog_byte(XOP_DEF_FILE);
        if ($urandom_range(3) != 0) gen_file_entry();
        else gen_list_end();
      end
    end else if (r < 95) begin
      send(SEC_D1, (rec_phase == D1_CHAR) ? KIND_TWO : KIND_FOUR, $urandom,
           1'($urandom_range(1)));
    end else begin
      send($urandom_range(1) ? 2'd3 : 2'd0, 2'($urandom_range(3)), $urandom,
           1'($urandom_range(1)));
    end
  endtask

  // Transfers on the result side are compared against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: valid=%0b line=%h file=%h err=%0d",
                     result.line_valid, result.line_number, result.file_number,
                     result.error_code);
        end else begin
          want = expected_results.pop_front();
          if (result.line_valid !== want.line_valid ||
              result.line_number !== want.line_number ||
              result.file_number !== want.file_number ||
              result.error_code !== want.error_code) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: expected valid=%0b line=%h file=%h err=%0d, ",
                        "got valid=%0b line=%h file=%h err=%0d"},
                       want.line_valid, want.line_number, want.file_number,
                       want.error_code, result.line_valid, result.line_number,
                       result.file_number, result.error_code);
          end
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  initial begin
    #20_000_000;
    $display("tb_dwarf_line_program_tracker_top NOT OK");
    $finish;
  end

  initial begin
    dir_row_t    rows[$];
    dir_row_t    row;
    result_t     d1_line;
    logic [31:0] ver;
    logic [7:0]  obase;
    int          r;
    bit          paused;

    // Predictor reset state.
    prog_phase = PH_SIZE;
    rec_phase = D1_SIZE;
    base_step = '0;
    line_span = '0;
    special_base = '0;
    oplen_left = '0;
    file_defined = 1'b0;
    cur_line = 32'd1;
    cur_file = 32'd1;
    leb_acc = '0;
    leb_sh = '0;
    halted = 1'b0;
    held_err = ERR_NONE;
    paused = 1'b0;

    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    err_pick = $urandom_range(ERR_D2_SIZE, ERR_RANGE0);

    // Directed rows: ignored sections, line-section extremes, then the fixed header prefix.
    row.fixed = 1'b1;
    row.want = '0;
    row.it = '{2'd0, KIND_STR, 32'hFFFF_FFFF, 1'b1};
    rows.push_back(row);
    row.it = '{2'd3, KIND_FOUR, 32'h0, 1'b0};
    rows.push_back(row);
    row.it = '{SEC_D1, KIND_FOUR, 32'hFFFF_FFFF, 1'b0};
    rows.push_back(row);
    row.it = '{SEC_D1, KIND_FOUR, 32'h0, 1'b1};
    rows.push_back(row);
    d1_line = '{1'b1, 32'hFFFF_FFFF, 32'd1, ERR_NONE};
    row.want = d1_line;
    row.it = '{SEC_D1, KIND_FOUR, 32'hFFFF_FFFF, 1'b0};
    rows.push_back(row);
    row.want = '0;
    row.it = '{SEC_D1, KIND_TWO, 32'hFFFF_FFFF, 1'b0};
    rows.push_back(row);
    row.it = '{SEC_D1, KIND_FOUR, 32'h0, 1'b0};
    rows.push_back(row);
    row.want = '{1'b1, 32'h0, 32'd1, ERR_NONE};
    row.it = '{SEC_D1, KIND_FOUR, 32'h0, 1'b0};
    rows.push_back(row);
    row.want = '0;
    row.it = '{SEC_D2, KIND_FOUR, 32'hFFFF_FFFF, 1'b0};
    rows.push_back(row);
    // The version row carries a bad version on runs that end in a version error.
    ver = LINE_PROG_VERSION;
    if (err_pick == ERR_VERSION) begin
      ver = $urandom;
      if (ver == LINE_PROG_VERSION) ver = 32'hFFFF_FFFF;
      row.want = '{1'b0, 32'h0, 32'h0, ERR_VERSION};
    end
    row.it = '{SEC_D2, KIND_TWO, ver, 1'b0};
    rows.push_back(row);
    row.fixed = 1'b0;
    row.it = '{SEC_D2, KIND_FOUR, 32'h0, 1'b0};
    rows.push_back(row);
    row.it = '{SEC_D2, KIND_BYTE, 32'hFFFF_FFFF, 1'b0};
    rows.push_back(row);
    row.it = '{SEC_D2, KIND_BYTE, 32'h0, 1'b0};
    rows.push_back(row);
    row.it = '{SEC_D2, KIND_BYTE, $urandom, 1'b0};
    rows.push_back(row);
    if (err_pick == ERR_RANGE0)
      row.it = '{SEC_D2, KIND_BYTE, {24'($urandom), 8'd0}, 1'b0};
    else if ($urandom_range(1))
      row.it = '{SEC_D2, KIND_BYTE, {24'($urandom), 8'($urandom_range(1, 5))}, 1'b0};
    else
      row.it = '{SEC_D2, KIND_BYTE, {24'($urandom), 8'($urandom_range(1, 255))}, 1'b0};
    rows.push_back(row);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send(rows[i].it.section, rows[i].it.kind, rows[i].it.value, rows[i].it.string_empty,
           rows[i].fixed, rows[i].want);

    // Rest of the header: opcode base, opcode lengths, directories and files.
    r = $urandom_range(9);
    obase = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'($urandom_range(14, 255)) :
            8'($urandom_range(2, 13));
    prog_byte({24'($urandom), obase});
    if (obase > 1) repeat (obase - 1) prog_byte($urandom);
    repeat ($urandom_range(3)) prog_str(1'b0);
    gen_list_end();
    repeat ($urandom_range(2)) gen_file_entry();
    gen_list_end();

    // Opcode stream under the four idling mixes.
    while (items_sent < ITEM_TARGET) begin
      case (items_sent * 4 / ITEM_TARGET)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 74; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 74; end
        default: begin send_idle = 28; recv_stall = 28; end
      endcase
      if (!paused && items_sent > ITEM_TARGET / 2) begin
        // Hold off until the tracker has returned everything owed.
        paused = 1'b1;
        item_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end
      gen_op();
    end

    // The halting error chosen for this run, then items that must echo it.
    case (err_pick)
      ERR_D2_SIZE: send(SEC_D2, KIND_TWO, $urandom_range(255), 1'b0);
      ERR_SUBOP: begin
        prog_op(OP_EXTENDED);
        gen_leb();
        ver = $urandom;
        if (ver >= XOP_END_SEQ && ver <= XOP_DEF_FILE) ver = 32'd0;
        prog_byte(ver);
      end
      ERR_NONZERO: begin
        prog_op(OP_EXTENDED);
        gen_leb();
        prog_byte(XOP_DEF_FILE);
        prog_byte($urandom | 32'd1);
      end
      ERR_BYTE: prog_byte($urandom_range(256, 65535) | ($urandom & 32'hFFFF_0000));
      ERR_D1_SIZE: send(SEC_D1, KIND_BYTE, $urandom, 1'b0);
      ERR_RANGE0: prog_byte($urandom_range(10, 255));
      default: ;
    endcase
    repeat (6)
      send(2'($urandom_range(3)), 2'($urandom_range(3)), $urandom,
           1'($urandom_range(1)));
    item_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("tb_dwarf_line_program_tracker_top OK");
    else $display("tb_dwarf_line_program_tracker_top NOT OK");
    $finish;
  end

endmodule
